>>> design/vrem_pkg.sv
// ============================================================================
// vrem_pkg: shared definitions for the vertical-retrace edge rate meter
// Field widths, register indexes, reset values and the divider status type.
// ============================================================================
package vrem_pkg;

    localparam int TICK_W  = 16;
    localparam int CNT_W   = 24;
    localparam int RATE_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 3;

    // Divider geometry: dividend holds ticks * 1000 or edges * 10000, divisor holds tick rate or ms.
    localparam int DIVD_W  = 38;
    localparam int DVSR_W  = 26;
    localparam int STEP_W  = $clog2(DIVD_W);

    localparam logic [CIDX_W-1:0] CFG_WINDOW_TICKS = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_TICK_RATE_HZ = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SAMPLE_CAP   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MIN_RATE_X10 = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MAX_RATE_X10 = 3'd4;

    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd63;
    localparam logic [TICK_W-1:0] TICK_RATE_RST    = 16'd250;
    localparam logic [CNT_W-1:0]  SAMPLE_CAP_RST   = 24'd2000000;
    localparam logic [RATE_W-1:0] MIN_RATE_RST     = 16'd400;
    localparam logic [RATE_W-1:0] MAX_RATE_RST     = 16'd2000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> design/vrem_if.sv
// ============================================================================
// vrem_if: valid/ready channels of the edge rate meter
// One interface for retrace samples and one for window results.
// ============================================================================
interface vrem_samp_if;
    logic valid;
    logic ready;
    logic start_req;
    logic retrace;
    logic tick;

    modport source (output valid, output start_req, output retrace, output tick,
                    input ready);
    modport sink   (input valid, input start_req, input retrace, input tick,
                    output ready);
endinterface

interface vrem_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] rate_x10;
    logic [23:0] samples_seen;
    logic [23:0] edges_seen;

    modport source (output valid, output rate_x10, output samples_seen,
                    output edges_seen, input ready);
    modport sink   (input valid, input rate_x10, input samples_seen,
                    input edges_seen, output ready);
endinterface

>>> design/vrem_div.sv
// ============================================================================
// vrem_div: bit-serial restoring divider
// Produces one quotient bit per cycle; a start pulse loads new operands.
// ============================================================================
module vrem_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vrem_pkg::DIVD_W-1:0]   dividend,
    input  logic [vrem_pkg::DVSR_W-1:0]   divisor,
    output vrem_pkg::div_stat_t           stat,
    output logic [vrem_pkg::DIVD_W-1:0]   quotient
);
    import vrem_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;

    logic [DVSR_W:0]   trial;
    logic              fits;

    // Shift the next dividend bit into the partial remainder and try the divisor.
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? DVSR_W'(trial - {1'b0, dvsr_reg}) : trial[DVSR_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> design/vretrace_edge_rate_meter_unit.sv
// ============================================================================
// vretrace_edge_rate_meter_unit: vertical-retrace edge rate meter
// Counts retrace samples, rising edges and timer ticks in a gated window and
// reports the edge rate in tenths of hertz when the window closes.
// ============================================================================
//
//  Channel | Direction | Handshake      | Payload
//  --------+-----------+----------------+-----------------------------------------
//  samp    | in        | valid / ready  | start_req, retrace, tick
//  res     | out       | valid / ready  | rate_x10, samples_seen, edges_seen
//  cfg     | in        | cfg_we only    | cfg_index, cfg_data (write only)
//
//  samp.ready is high whenever the sequencer is in ST_RUN, so samples stream at
//  one per cycle until a window closes. A sample that closes the window starts up
//  to two passes of the bit-serial divider (38 quotient bits each, one per cycle).
//  With the sequencer steps around them, samp.ready stays low after the closing
//  transaction until the result is loaded into res, shorter when a divisor is zero,
//  and longer while the previous result still waits in res.
//  Reset restores the register defaults and leaves no window open. A stall on
//  res does not block sampling until the next window closes.
//
module vretrace_edge_rate_meter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    vrem_samp_if.sink                     samp,
    vrem_res_if.source                    res,
    input  logic                          cfg_we,
    input  logic [vrem_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [vrem_pkg::CFG_W-1:0]    cfg_data
);
    import vrem_pkg::*;

    // Sequencer codes.
    localparam logic [2:0] ST_RUN  = 3'd0;   // counting samples
    localparam logic [2:0] ST_MS   = 3'd1;   // start ticks*1000 / tick_rate
    localparam logic [2:0] ST_MS_W = 3'd2;   // wait for ms quotient
    localparam logic [2:0] ST_RT   = 3'd3;   // start edges*10000 / ms
    localparam logic [2:0] ST_RT_W = 3'd4;   // wait for rate quotient
    localparam logic [2:0] ST_OUT  = 3'd5;   // hand the result to the output register

    // Configuration registers.
    logic [TICK_W-1:0] window_ticks_reg;
    logic [TICK_W-1:0] tick_rate_reg;
    logic [CNT_W-1:0]  sample_cap_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] max_rate_reg;

    // Window state.
    logic [2:0]        state_reg;
    logic              active_reg;
    logic              prev_bit_reg;
    logic [CNT_W-1:0]  sample_count_reg;
    logic [CNT_W-1:0]  edge_count_reg;
    logic [TICK_W-1:0] elapsed_reg;
    logic [DVSR_W-1:0] ms_reg;
    logic [RATE_W-1:0] rate_reg;

    // Output register.
    logic              res_valid_reg;
    logic [RATE_W-1:0] res_rate_reg;
    logic [CNT_W-1:0]  res_samples_reg;
    logic [CNT_W-1:0]  res_edges_reg;

    logic              samp_fire;
    logic              res_load;
    logic [TICK_W-1:0] elapsed_next;
    logic [CNT_W-1:0]  sample_next;
    logic [CNT_W-1:0]  edge_next;
    logic              window_over;
    logic              cap_over;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DVSR_W-1:0] div_divisor;
    div_stat_t         div_stat;
    logic [DIVD_W-1:0] div_quotient;
    logic [DIVD_W-1:0] ticks_x1000;
    logic [DIVD_W-1:0] edges_x10000;
    logic [DIVD_W-1:0] elapsed_ext;
    logic [DIVD_W-1:0] edges_ext;
    logic              rate_ok;

    assign samp.ready = (state_reg == ST_RUN);
    assign samp_fire  = samp.valid && samp.ready;

    // Saturating counters. The tick is added first and decides the close;
    // the sample and edge counts only move when the window stays open.
    assign elapsed_next = (samp.tick && (elapsed_reg != {TICK_W{1'b1}}))
                          ? elapsed_reg + 1'b1 : elapsed_reg;
    assign sample_next  = (sample_count_reg != {CNT_W{1'b1}})
                          ? sample_count_reg + 1'b1 : sample_count_reg;
    assign edge_next    = (samp.retrace && !prev_bit_reg && (edge_count_reg != {CNT_W{1'b1}}))
                          ? edge_count_reg + 1'b1 : edge_count_reg;
    assign window_over  = (elapsed_next >= window_ticks_reg);
    assign cap_over     = (sample_next >= sample_cap_reg);

    // Constant multiplies as shift-and-add: 1000 = 1024 - 16 - 8 and
    // 10000 = 8192 + 1024 + 512 + 256 + 16.
    assign elapsed_ext  = DIVD_W'(elapsed_reg);
    assign edges_ext    = DIVD_W'(edge_count_reg);
    assign ticks_x1000  = (elapsed_ext << 10) - (elapsed_ext << 4) - (elapsed_ext << 3);
    assign edges_x10000 = (edges_ext << 13) + (edges_ext << 10) + (edges_ext << 9)
                        + (edges_ext << 8) + (edges_ext << 4);

    // The divider is shared by both passes. A zero divisor never starts it:
    // a zero tick rate or a zero ms both end in a rate of 0.
    assign div_start    = ((state_reg == ST_MS) && (tick_rate_reg != '0))
                       || ((state_reg == ST_RT) && (ms_reg != '0));
    assign div_dividend = (state_reg == ST_MS) ? ticks_x1000 : edges_x10000;
    assign div_divisor  = (state_reg == ST_MS) ? DVSR_W'(tick_rate_reg) : ms_reg;

    vrem_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // The rate is accepted only inside [min, max]; anything wider than the
    // output field is above max by construction.
    assign rate_ok = (div_quotient[DIVD_W-1:RATE_W] == '0)
                  && (div_quotient[RATE_W-1:0] >= min_rate_reg)
                  && (div_quotient[RATE_W-1:0] <= max_rate_reg);

    assign res_load = (state_reg == ST_OUT) && (!res_valid_reg || res.ready);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= WINDOW_TICKS_RST;
            tick_rate_reg    <= TICK_RATE_RST;
            sample_cap_reg   <= SAMPLE_CAP_RST;
            min_rate_reg     <= MIN_RATE_RST;
            max_rate_reg     <= MAX_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[TICK_W-1:0];
                CFG_TICK_RATE_HZ: tick_rate_reg    <= cfg_data[TICK_W-1:0];
                CFG_SAMPLE_CAP:   sample_cap_reg   <= cfg_data[CNT_W-1:0];
                CFG_MIN_RATE_X10: min_rate_reg     <= cfg_data[RATE_W-1:0];
                CFG_MAX_RATE_X10: max_rate_reg     <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Window counting and close sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            active_reg       <= 1'b0;
            prev_bit_reg     <= 1'b0;
            sample_count_reg <= '0;
            edge_count_reg   <= '0;
            elapsed_reg      <= '0;
            ms_reg           <= '0;
            rate_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                ST_RUN:
                begin
                    if (samp_fire)
                    begin
                        if (samp.start_req)
                        begin
                            // A start always reopens the window, even mid-window.
                            active_reg       <= 1'b1;
                            prev_bit_reg     <= samp.retrace;
                            sample_count_reg <= '0;
                            edge_count_reg   <= '0;
                            elapsed_reg      <= '0;
                        end
                        else if (active_reg)
                        begin
                            elapsed_reg <= elapsed_next;
                            if (window_over)
                            begin
                                active_reg <= 1'b0;
                                state_reg  <= ST_MS;
                            end
                            else
                            begin
                                sample_count_reg <= sample_next;
                                edge_count_reg   <= edge_next;
                                prev_bit_reg     <= samp.retrace;
                                if (cap_over)
                                begin
                                    active_reg <= 1'b0;
                                    state_reg  <= ST_MS;
                                end
                            end
                        end
                    end
                end
                ST_MS:
                begin
                    if (tick_rate_reg == '0)
                    begin
                        ms_reg    <= '0;
                        state_reg <= ST_RT;
                    end
                    else
                    begin
                        state_reg <= ST_MS_W;
                    end
                end
                ST_MS_W:
                begin
                    if (div_stat.done)
                    begin
                        ms_reg    <= div_quotient[DVSR_W-1:0];
                        state_reg <= ST_RT;
                    end
                end
                ST_RT:
                begin
                    if (ms_reg == '0)
                    begin
                        rate_reg  <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_RT_W;
                    end
                end
                ST_RT_W:
                begin
                    if (div_stat.done)
                    begin
                        rate_reg  <= rate_ok ? div_quotient[RATE_W-1:0] : '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (res_load)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    // Output register: holds one result so counting can resume while it waits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_rate_reg    <= rate_reg;
            res_samples_reg <= sample_count_reg;
            res_edges_reg   <= edge_count_reg;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.rate_x10     = res_rate_reg;
    assign res.samples_seen = res_samples_reg;
    assign res.edges_seen   = res_edges_reg;

endmodule

>>> design/vrem_chk.sv
// ============================================================================
// vrem_chk: port-level checks for the edge rate meter
// Watches the result channel and is bound to the top level.
// ============================================================================
module vrem_chk
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [15:0] rate_x10,
    input  logic [23:0] samples_seen,
    input  logic [23:0] edges_seen
);

    // A waiting result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result withdrawn before it was taken");

    // A waiting result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            ($stable(rate_x10) && $stable(samples_seen) && $stable(edges_seen)))
        else $error("result changed while stalled");

    // Every counted edge belongs to a counted sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (edges_seen <= samples_seen))
        else $error("more edges than samples in a window");

    // A nonzero rate needs at least one edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (rate_x10 != 16'd0)) |-> (edges_seen != 24'd0))
        else $error("nonzero rate reported without edges");

endmodule

bind vretrace_edge_rate_meter_unit vrem_chk u_vrem_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .rate_x10     (res.rate_x10),
    .samples_seen (res.samples_seen),
    .edges_seen   (res.edges_seen)
);

>>> tb/vretrace_edge_rate_meter_unit_test.sv
// ============================================================================
// vretrace_edge_rate_meter_unit_test: self-checking bench for the edge rate meter
// Streams retrace sample transactions through the meter under several register
// settings, predicts every window result in the bench, and checks each result
// transaction field by field while both channels idle and stall at random.
// ============================================================================
module vretrace_edge_rate_meter_unit_test;

    import vrem_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    // A closing window runs up to two divider passes; this is a wide margin.
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 4000000;

    // One window result as the meter reports it.
    typedef struct packed {
        logic [RATE_W-1:0] rate_x10;
        logic [CNT_W-1:0]  samples_seen;
        logic [CNT_W-1:0]  edges_seen;
    } window_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    vrem_samp_if samp_ch ();
    vrem_res_if  res_ch ();

    vretrace_edge_rate_meter_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .samp      (samp_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench copy of the meter registers.
    logic [TICK_W-1:0] reg_window;
    logic [TICK_W-1:0] reg_tick_rate;
    logic [CNT_W-1:0]  reg_cap;
    logic [RATE_W-1:0] reg_min_rate;
    logic [RATE_W-1:0] reg_max_rate;

    // Bench copy of the window state.
    logic              win_open;
    logic              last_bit;
    logic [CNT_W-1:0]  n_samples;
    logic [CNT_W-1:0]  n_edges;
    logic [TICK_W-1:0] n_ticks;

    // Results predicted but not yet seen on the result channel.
    window_result_t    pending_results[$];

    int                mismatches;
    int                items_taken;
    int                cycle_count;

    // Sender burst bookkeeping: transactions left in the current burst.
    int                burst_left;

    // Receiver stall pattern state.
    int                stall_left;
    int                stall_mode;
    logic [31:0]       stall_bits;

    // ------------------------------------------------------------------------
    // Clock and cycle limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor. Called once for each accepted sample transaction, in order.
    // A closing window pushes exactly one expected result.
    // ------------------------------------------------------------------------
    task automatic close_window_result();
        longint unsigned ms;
        longint unsigned rate;
        window_result_t  res;
        begin
            ms   = 0;
            rate = 0;
            if (reg_tick_rate != 0)
                ms = (longint'(n_ticks) * 64'd1000) / longint'(reg_tick_rate);
            if (ms != 0)
            begin
                rate = (longint'(n_edges) * 64'd10000) / ms;
                // Out-of-range rates, and every rate when min exceeds max, read as 0.
                if (rate < longint'(reg_min_rate) || rate > longint'(reg_max_rate))
                    rate = 0;
            end
            res.rate_x10     = rate[RATE_W-1:0];
            res.samples_seen = n_samples;
            res.edges_seen   = n_edges;
            pending_results.push_back(res);
            win_open = 1'b0;
        end
    endtask

    task automatic meter_predict(input logic start_req, input logic retrace, input logic tick);
        begin
            if (start_req || win_open)
                items_taken++;
            if (start_req)
            begin
                // A start always reopens the window, even in the middle of one,
                // and its tick field is ignored.
                win_open  = 1'b1;
                last_bit  = retrace;
                n_samples = '0;
                n_edges   = '0;
                n_ticks   = '0;
            end
            else if (win_open)
            begin
                if (tick && n_ticks != {TICK_W{1'b1}})
                    n_ticks = n_ticks + 1'b1;
                if (n_ticks >= reg_window)
                begin
                    // The sample that reaches the window is not counted.
                    close_window_result();
                end
                else
                begin
                    if (n_samples != {CNT_W{1'b1}})
                        n_samples = n_samples + 1'b1;
                    if (retrace && !last_bit && n_edges != {CNT_W{1'b1}})
                        n_edges = n_edges + 1'b1;
                    last_bit = retrace;
                    if (n_samples >= reg_cap)
                        close_window_result();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample sender. It is entered at a rising edge and returns at the edge
    // where its transaction was accepted, so a following transaction can
    // keep valid high without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic start_req, input logic retrace, input logic tick);
        int gap;
        begin
            if (burst_left == 0)
            begin
                // Mostly short gaps, now and then a long one, sometimes none.
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
                burst_left = $urandom_range(1, 40);
                if (gap > 0)
                begin
                    samp_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            samp_ch.valid     <= 1'b1;
            samp_ch.start_req <= start_req;
            samp_ch.retrace   <= retrace;
            samp_ch.tick      <= tick;
            do
                @(posedge clk);
            while (!samp_ch.ready);
            burst_left--;
            meter_predict(start_req, retrace, tick);
        end
    endtask

    // Lowers valid and waits until every predicted
    // result has arrived.
    task automatic wait_for_results();
        begin
            samp_ch.valid <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Writes all five registers while the meter is idle.
    task automatic apply_settings(input int unsigned window, input int unsigned tick_rate,
                                  input int unsigned cap, input int unsigned min_rate,
                                  input int unsigned max_rate);
        begin
            wait_for_results();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_WINDOW_TICKS;
            cfg_data  <= CFG_W'(window);
            @(posedge clk);
            cfg_index <= CFG_TICK_RATE_HZ;
            cfg_data  <= CFG_W'(tick_rate);
            @(posedge clk);
            cfg_index <= CFG_SAMPLE_CAP;
            cfg_data  <= CFG_W'(cap);
            @(posedge clk);
            cfg_index <= CFG_MIN_RATE_X10;
            cfg_data  <= CFG_W'(min_rate);
            @(posedge clk);
            cfg_index <= CFG_MAX_RATE_X10;
            cfg_data  <= CFG_W'(max_rate);
            @(posedge clk);
            cfg_we <= 1'b0;
            reg_window    = TICK_W'(window);
            reg_tick_rate = TICK_W'(tick_rate);
            reg_cap       = CNT_W'(cap);
            reg_min_rate  = RATE_W'(min_rate);
            reg_max_rate  = RATE_W'(max_rate);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver and checker. The receiver cycles through stall modes:
    // always ready, a bit pattern, coin flips and long near-total stalls.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        begin
            if (exp_val != act_val)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        window_result_t exp_res;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual rate %0d samples %0d edges %0d",
                             $time, res_ch.rate_x10, res_ch.samples_seen, res_ch.edges_seen);
                    mismatches++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    check_field("rate_x10", exp_res.rate_x10, res_ch.rate_x10);
                    check_field("samples_seen", exp_res.samples_seen, res_ch.samples_seen);
                    check_field("edges_seen", exp_res.edges_seen, res_ch.edges_seen);
                end
            end

            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 150);
                stall_bits = $urandom();
            end
            stall_left--;
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= stall_bits[stall_left % 32];
                2:       res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Random windows. Most traffic is a start followed by samples until the
    // window closes; a few windows are cut short by a fresh start, and idle
    // noise is sprinkled between windows.
    // ------------------------------------------------------------------------
    task automatic run_windows(input int budget, input int tick_lo, input int tick_hi);
        int   stop_at;
        int   tick_pct;
        int   toggle_pct;
        int   abort_at;
        int   n;
        logic cur_bit;
        begin
            stop_at = items_taken + budget;
            while (items_taken < stop_at)
            begin
                // Samples outside a window are ignored by the meter.
                repeat ($urandom_range(0, 2))
                    send_sample(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

                tick_pct   = $urandom_range(tick_lo, tick_hi);
                toggle_pct = $urandom_range(0, 100);
                abort_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : -1;
                cur_bit    = 1'($urandom_range(0, 1));
                send_sample(1'b1, cur_bit, 1'($urandom_range(0, 1)));
                n = 0;
                while (win_open)
                begin
                    if (n == abort_at)
                    begin
                        cur_bit = 1'($urandom_range(0, 1));
                        send_sample(1'b1, cur_bit, 1'($urandom_range(0, 1)));
                        abort_at = -1;
                        n = 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 99) < toggle_pct)
                            cur_bit = ~cur_bit;
                        send_sample(1'b0, cur_bit, ($urandom_range(0, 99) < tick_pct));
                        n++;
                    end
                end

                // Now and then hold the sender until the result is back.
                if ($urandom_range(0, 7) == 0)
                    wait_for_results();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Idle samples, a plain window closed by its tick count, and a restart
    // in the middle of an open window.
    task automatic test_basic_window();
        begin
            apply_settings(4, 1000, 24'hFFFFFF, 0, 16'hFFFF);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b1, 1'b1, 1'b1);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b0);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b1, 1'b0, 1'b0);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b1, 1'b1, 1'b0);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);
            wait_for_results();
        end
    endtask

    // Zero window, zero cap, zero tick rate, and a minimum above the maximum.
    task automatic test_corner_settings();
        begin
            apply_settings(0, 1000, 24'hFFFFFF, 0, 16'hFFFF);
            send_sample(1'b1, 1'b0, 1'b0);
            send_sample(1'b0, 1'b1, 1'b0);

            apply_settings(100, 1000, 0, 0, 16'hFFFF);
            send_sample(1'b1, 1'b0, 1'b0);
            send_sample(1'b0, 1'b1, 1'b1);

            apply_settings(3, 0, 24'hFFFFFF, 0, 16'hFFFF);
            send_sample(1'b1, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);

            apply_settings(3, 1000, 24'hFFFFFF, 16'hFFFF, 0);
            send_sample(1'b1, 1'b0, 1'b0);
            send_sample(1'b0, 1'b1, 1'b1);
            send_sample(1'b0, 1'b0, 1'b1);
            send_sample(1'b0, 1'b1, 1'b1);
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Random tests.
    // ------------------------------------------------------------------------

    // Windows under the reset register values, before any write.
    task automatic test_reset_defaults();
        begin
            run_windows(300, 40, 100);
        end
    endtask

    // Fixed settings that hit the register extremes and the rejection paths.
    task automatic test_extreme_settings();
        begin
            apply_settings(16, 1000, 24'hFFFFFF, 0, 16'hFFFF);
            run_windows(250, 20, 100);
            // Widest window; the cap closes every window first.
            apply_settings(16'hFFFF, 1, 30, 1, 16'hFFFF);
            run_windows(150, 1, 100);
            // Fastest tick rate, so short windows give zero milliseconds.
            apply_settings(16'hFFFF, 16'hFFFF, 25, 0, 16'hFFFF);
            run_windows(100, 1, 100);
            // The cap closes every window before the tick count reaches the window.
            apply_settings(8, 3, 5, 100, 30000);
            run_windows(150, 10, 100);
            apply_settings(1, 0, 24'hFFFFFF, 0, 16'hFFFF);
            run_windows(100, 1, 100);
            apply_settings(12, 250, 24'hFFFFFF, 16'hFFFF, 0);
            run_windows(100, 10, 100);
        end
    endtask

    task automatic test_random_settings();
        begin
            repeat (3)
            begin
                apply_settings($urandom_range(1, 40),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                           : $urandom_range(100, 5000),
                               $urandom_range(1, 60),
                               $urandom_range(0, 3000),
                               $urandom_range(0, 65535));
                run_windows(120, 10, 100);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        samp_ch.valid     <= 1'b0;
        samp_ch.start_req <= 1'b0;
        samp_ch.retrace   <= 1'b0;
        samp_ch.tick      <= 1'b0;

        mismatches    = 0;
        items_taken   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        stall_left    = 0;
        stall_mode    = 0;
        stall_bits    = '0;

        reg_window    = WINDOW_TICKS_RST;
        reg_tick_rate = TICK_RATE_RST;
        reg_cap       = SAMPLE_CAP_RST;
        reg_min_rate  = MIN_RATE_RST;
        reg_max_rate  = MAX_RATE_RST;
        win_open      = 1'b0;
        last_bit      = 1'b0;
        n_samples     = '0;
        n_edges       = '0;
        n_ticks       = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_basic_window();
        test_corner_settings();
        test_extreme_settings();
        test_random_settings();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
design/vrem_pkg.sv
design/vrem_if.sv
design/vrem_div.sv
design/vretrace_edge_rate_meter_unit.sv
design/vrem_chk.sv
tb/vretrace_edge_rate_meter_unit_test.sv
